// ===== src/vzd_pkg.sv =====
// ----------------------------------------------------------------------------
// vzd_pkg
// Shared widths, value kind codes and zigzag helpers for the varint and
// zigzag value decoder.
// ----------------------------------------------------------------------------
package vzd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned VALUE_W = 64;

  typedef logic [KIND_W-1:0]  kind_t;
  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [VALUE_W-1:0] value_t;

  localparam kind_t KIND_BYTE  = 3'd0;
  localparam kind_t KIND_U32   = 3'd1;
  localparam kind_t KIND_S32   = 3'd2;
  localparam kind_t KIND_U64   = 3'd3;
  localparam kind_t KIND_S64   = 3'd4;
  localparam kind_t KIND_FLOAT = 3'd5;

  localparam pos_t LAST_POS_32    = 4'd4;
  localparam pos_t LAST_POS_64    = 4'd9;
  localparam pos_t LAST_POS_FLOAT = 4'd3;

  function automatic value_t zigzag32(input logic [31:0] v);
    logic [31:0] r;
    begin
      r = (v >> 1) ^ {32{v[0]}};
      zigzag32 = {{32{r[31]}}, r};
    end
  endfunction

  function automatic value_t zigzag64(input value_t v);
    begin
      zigzag64 = (v >> 1) ^ {VALUE_W{v[0]}};
    end
  endfunction

endpackage

// ===== src/varint_zigzag_value_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// varint_zigzag_value_decoder_unit
// Decodes raw bytes, base-128 varints (plain or zigzag) and packed floats
// from a byte stream, one byte per word, with a sticky error flag.
// ----------------------------------------------------------------------------
//   channel | words                    | handshake
//   in      | data_byte, value_kind    | in_valid, in_stall
//   out     | value, error             | out_valid, out_stall
//
// One input word is taken per cycle while in_stall is low; its result, if any, appears in the
// output register on the next cycle. The decode is a single combinational
// pass from the byte and the decoder state to the state and result registers.
// Reset clears the error flag, byte position and output valid.
// in_stall is raised only while a result waits in the output register and
// out_stall holds it there.
// ----------------------------------------------------------------------------
module varint_zigzag_value_decoder_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [vzd_pkg::BYTE_W-1:0]    data_byte,
  input  logic [vzd_pkg::KIND_W-1:0]    value_kind,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [vzd_pkg::VALUE_W-1:0]   value,
  output logic                          error
);

  logic             failed;
  logic             failed_next;
  vzd_pkg::pos_t    pos;
  vzd_pkg::pos_t    pos_next;
  vzd_pkg::value_t  acc;
  vzd_pkg::value_t  acc_next;
  vzd_pkg::kind_t   kind;
  vzd_pkg::kind_t   kind_next;
  logic             out_valid_next;
  vzd_pkg::value_t  value_next;
  logic             error_next;

  logic             take;
  logic             first;
  vzd_pkg::kind_t   cur_kind;
  vzd_pkg::value_t  base;
  logic [6:0]       shift;
  vzd_pkg::value_t  var_acc;
  vzd_pkg::value_t  flt_acc;
  logic             emit;
  vzd_pkg::value_t  emit_value;
  logic             emit_error;

  assign in_stall = out_valid && out_stall;
  assign take     = in_valid && !in_stall;
  assign first    = (pos == '0);
  assign cur_kind = first ? value_kind : kind;
  assign base     = first ? '0 : acc;
  assign shift    = ({3'b000, pos} << 3) - {3'b000, pos};
  assign var_acc  = base | ({{(vzd_pkg::VALUE_W-7){1'b0}}, data_byte[6:0]} << shift[5:0]);
  assign flt_acc  = base | ({{(vzd_pkg::VALUE_W-8){1'b0}}, data_byte} << {pos[1:0], 3'b000});

  always_comb begin
    failed_next = failed;
    pos_next    = pos;
    acc_next    = acc;
    kind_next   = cur_kind;
    emit        = 1'b0;
    emit_value  = '0;
    emit_error  = 1'b0;
    if (failed) begin
      kind_next  = kind;
      emit       = 1'b1;
      emit_error = 1'b1;
    end else begin
      case (cur_kind)
        vzd_pkg::KIND_U32, vzd_pkg::KIND_S32: begin
          if (pos > vzd_pkg::LAST_POS_32 ||
              (pos == vzd_pkg::LAST_POS_32 && data_byte[7:4] != 4'd0)) begin
            failed_next = 1'b1;
            emit        = 1'b1;
            emit_error  = 1'b1;
          end else if (!data_byte[7]) begin
            emit       = 1'b1;
            emit_value = (cur_kind == vzd_pkg::KIND_S32) ?
                         vzd_pkg::zigzag32(var_acc[31:0]) : {32'd0, var_acc[31:0]};
          end else begin
            pos_next = pos + 4'd1;
            acc_next = var_acc;
          end
        end
        vzd_pkg::KIND_U64, vzd_pkg::KIND_S64: begin
          if (pos > vzd_pkg::LAST_POS_64 ||
              (pos == vzd_pkg::LAST_POS_64 && data_byte[7:1] != 7'd0)) begin
            failed_next = 1'b1;
            emit        = 1'b1;
            emit_error  = 1'b1;
          end else if (!data_byte[7]) begin
            emit       = 1'b1;
            emit_value = (cur_kind == vzd_pkg::KIND_S64) ?
                         vzd_pkg::zigzag64(var_acc) : var_acc;
          end else begin
            pos_next = pos + 4'd1;
            acc_next = var_acc;
          end
        end
        vzd_pkg::KIND_FLOAT: begin
          if (first && data_byte == 8'd0) begin
            emit = 1'b1;
          end else if (pos >= vzd_pkg::LAST_POS_FLOAT) begin
            emit       = 1'b1;
            emit_value = {32'd0, flt_acc[8:0], flt_acc[31:9]};
          end else begin
            pos_next = pos + 4'd1;
            acc_next = flt_acc;
          end
        end
        default: begin
          emit       = 1'b1;
          emit_value = {{(vzd_pkg::VALUE_W-8){1'b0}}, data_byte};
        end
      endcase
    end
    if (emit) begin
      pos_next = '0;
      acc_next = '0;
    end
  end

  always_comb begin
    out_valid_next = out_valid && out_stall;
    value_next     = value;
    error_next     = error;
    if (take && emit) begin
      out_valid_next = 1'b1;
      value_next     = emit_value;
      error_next     = emit_error;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      failed    <= 1'b0;
      pos       <= '0;
      acc       <= '0;
      kind      <= vzd_pkg::KIND_BYTE;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        failed <= failed_next;
        pos    <= pos_next;
        acc    <= acc_next;
        kind   <= kind_next;
      end
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
    error <= error_next;
  end

endmodule

// ===== src/vzd_checker.sv =====
// ----------------------------------------------------------------------------
// vzd_checker
// Port-level checks for the varint and zigzag value decoder, bound to the
// top level.
// ----------------------------------------------------------------------------
module vzd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [vzd_pkg::BYTE_W-1:0]    data_byte,
  input logic [vzd_pkg::KIND_W-1:0]    value_kind,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [vzd_pkg::VALUE_W-1:0]   value,
  input logic                          error
);

  // A failed word always carries a zero value.
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> value == '0)
    else $error("error word with nonzero value");

  // Once an error is shown, every later word is an error as well.
  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |=> !out_valid || error)
    else $error("error flag did not stay set");

  // The input is held back only by a waiting, stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(value) && $stable(error))
    else $error("stalled output word changed");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(data_byte) && $stable(value_kind))
    else $error("stalled input word changed");

endmodule

bind varint_zigzag_value_decoder_unit vzd_checker u_vzd_checker (.*);
